/* design/brbd_pkg.sv */
package brbd_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int MAX_READ_DEF    = 64;
    localparam int WORD_BYTES_DEF  = 8;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 64;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;
    localparam int CAP_W    = 10;

    localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_PREPEND = 3'd1,
        OP_READ    = 3'd2,
        OP_COMMIT  = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_NO_DATA = 2'd2,
        ST_BAD_LEN = 2'd3
    } t_status;

endpackage

/* design/brbd_if.sv */
interface brbd_req_if
    import brbd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               keep;

    modport source (output valid, output operation, output data, output count,
                    output keep, input ready);
    modport sink   (input valid, input operation, input data, input count,
                    input keep, output ready);
endinterface

interface brbd_rsp_if
    import brbd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;
    logic [CAP_W-1:0]    bytes_held;
    logic                full_res;

    modport source (output valid, output status, output data_byte, output last,
                    output bytes_held, output full_res, input ready);
    modport sink   (input valid, input status, input data_byte, input last,
                    input bytes_held, input full_res, output ready);
endinterface

/* design/brbd_store.sv */
module brbd_store
    import brbd_pkg::*;
#(
    parameter int DEPTH  = STORE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(STORE_DEPTH_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so a stalled consumer keeps its byte.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/byte_ring_buffer_deque_core.sv */
// Byte ring buffer with prepend. Each transaction on i_req is an append, prepend, read,
// commit or clear; each produces one result on o_rsp, except a successful read of n > 0
// bytes, which produces n results with last on the final one. The ring lives in a
// byte-wide single-write-port store, so a successful append or prepend writes its bytes
// to the store one at a time before its result, and a read makes one store read per byte,
// whose data the store registers, and waits while o_rsp stalls. A new transaction is
// accepted while the previous result still waits in the output register. Writing the
// capacity register empties the buffer; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module byte_ring_buffer_deque_core
    import brbd_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_READ    = MAX_READ_DEF,
    parameter int WORD_BYTES  = WORD_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    brbd_req_if.sink         i_req,
    brbd_rsp_if.source       o_rsp
);

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int AW = ((IW > CAP_W) ? IW : CAP_W) + 2;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_WR      = 5'b00010,
        S_RD_ADDR = 5'b00100,
        S_RD_DATA = 5'b01000,
        S_EMIT    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CAP_W-1:0]   r_cap;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_tail, n_tail;
    logic [CAP_W-1:0]   r_held, n_held;

    logic [IW-1:0]      r_ptr, n_ptr;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [DATA_W-1:0]  r_data, n_data;
    t_status            r_status, n_status;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic                r_out_last, n_out_last;
    logic [CAP_W-1:0]    r_out_held, n_out_held;
    logic                r_out_full, n_out_full;

    logic              mem_we;
    logic              mem_re;
    logic [IW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    logic [AW-1:0] w_cap_p1, w_slots, w_cnt, w_held, w_room;
    logic [AW-1:0] w_head_add, w_head_fwd, w_head_back, w_tail_add, w_tail_fwd;
    logic [AW-1:0] w_held_dec;
    logic [IW-1:0] w_ptr_next;
    logic          w_accept, w_out_free, w_full;

    brbd_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_ptr),
        .i_wdata (r_data[BYTE_W-1:0]),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_cap_p1 = AW'(r_cap) + AW'(1);
    assign w_slots  = (w_cap_p1 > AW'(STORE_DEPTH)) ? AW'(STORE_DEPTH) : w_cap_p1;
    assign w_cnt    = AW'(i_req.count);
    assign w_held   = AW'(r_held);
    assign w_room   = w_slots - AW'(1) - w_held;
    assign w_full   = (w_held == w_slots - AW'(1));

    // Sums stay below twice the ring size, so one conditional subtract wraps them.
    assign w_head_add  = AW'(r_head) + w_cnt;
    assign w_head_fwd  = (w_head_add >= w_slots) ? w_head_add - w_slots : w_head_add;
    assign w_tail_add  = AW'(r_tail) + w_cnt;
    assign w_tail_fwd  = (w_tail_add >= w_slots) ? w_tail_add - w_slots : w_tail_add;
    assign w_head_back = (AW'(r_head) >= w_cnt) ? AW'(r_head) - w_cnt
                                                : AW'(r_head) + w_slots - w_cnt;
    assign w_held_dec  = w_held - w_cnt;

    assign w_ptr_next = (AW'(r_ptr) + AW'(1) == w_slots) ? '0 : r_ptr + IW'(1);

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    always_comb begin
        logic load;
        load         = 1'b0;
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_held       = r_held;
        n_ptr        = r_ptr;
        n_left       = r_left;
        n_data       = r_data;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_held   = r_out_held;
        n_out_full   = r_out_full;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_data   = i_req.data;
                    n_left   = i_req.count;
                    n_status = ST_OK;
                    n_state  = S_EMIT;
                    case (i_req.operation)
                        OP_APPEND, OP_PREPEND: begin
                            if ((i_req.operation == OP_APPEND && i_req.count == '0) ||
                                w_cnt > AW'(WORD_BYTES)) begin
                                n_status = ST_BAD_LEN;
                            end else if (w_cnt > w_room) begin
                                n_status = ST_NO_ROOM;
                            end else begin
                                n_held = r_held + CAP_W'(i_req.count);
                                if (i_req.operation == OP_APPEND) begin
                                    n_ptr  = r_tail;
                                    n_tail = w_tail_fwd[IW-1:0];
                                end else begin
                                    n_ptr  = w_head_back[IW-1:0];
                                    n_head = w_head_back[IW-1:0];
                                end
                                // A zero-length prepend changes nothing.
                                if (i_req.count != '0) begin
                                    n_state = S_WR;
                                end
                            end
                        end
                        OP_READ: begin
                            if (w_cnt > AW'(MAX_READ)) begin
                                n_status = ST_BAD_LEN;
                            end else if (w_cnt > w_held) begin
                                n_status = ST_NO_DATA;
                            end else begin
                                n_ptr = r_head;
                                if (!i_req.keep) begin
                                    n_held = w_held_dec[CAP_W-1:0];
                                    n_head = (w_held_dec == '0) ? '0 : w_head_fwd[IW-1:0];
                                    n_tail = (w_held_dec == '0) ? '0 : r_tail;
                                end
                                if (i_req.count != '0) begin
                                    n_state = S_RD_ADDR;
                                end
                            end
                        end
                        OP_COMMIT: begin
                            if (w_cnt > w_held) begin
                                n_status = ST_NO_DATA;
                            end else begin
                                n_held = w_held_dec[CAP_W-1:0];
                                n_head = (w_held_dec == '0) ? '0 : w_head_fwd[IW-1:0];
                                n_tail = (w_held_dec == '0) ? '0 : r_tail;
                            end
                        end
                        OP_CLEAR: begin
                            n_head = '0;
                            n_tail = '0;
                            n_held = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WR: begin
                mem_we = 1'b1;
                n_ptr  = w_ptr_next;
                n_data = r_data >> BYTE_W;
                n_left = r_left - COUNT_W'(1);
                if (r_left == COUNT_W'(1)) begin
                    n_state = S_EMIT;
                end
            end
            S_RD_ADDR: begin
                mem_re  = 1'b1;
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (w_out_free) begin
                    load         = 1'b1;
                    n_out_status = ST_OK;
                    n_out_byte   = mem_rdata;
                    n_out_last   = (r_left == COUNT_W'(1));
                    n_left       = r_left - COUNT_W'(1);
                    n_ptr        = w_ptr_next;
                    if (r_left == COUNT_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        // Fetch the next byte while this one moves to the output register.
                        mem_re    = 1'b1;
                        mem_raddr = w_ptr_next;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    load         = 1'b1;
                    n_out_status = r_status;
                    n_out_byte   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
            n_out_held  = r_held;
            n_out_full  = w_full;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap  <= i_cfg_data;
                r_head <= '0;
                r_tail <= '0;
                r_held <= '0;
            end else begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_left       <= n_left;
        r_data       <= n_data;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_held   <= n_out_held;
        r_out_full   <= n_out_full;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.data_byte  = r_out_byte;
    assign o_rsp.last       = r_out_last;
    assign o_rsp.bytes_held = r_out_held;
    assign o_rsp.full_res   = r_out_full;

endmodule

/* test/byte_ring_buffer_deque_core_tb.sv */
`timescale 1ns / 1ps

module byte_ring_buffer_deque_core_tb
    import brbd_pkg::*;
();

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int CFG_SETTLE  = 4;
    localparam int END_SETTLE  = 20;
    localparam int MAX_PRINTS  = 20;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    class ring_scoreboard;
        typedef struct packed {
            logic [STATUS_W-1:0] status;
            logic [BYTE_W-1:0]   data_byte;
            logic                last;
            logic [CAP_W-1:0]    bytes_held;
            logic                full_res;
        } t_ring_result;

        logic [BYTE_W-1:0] ring_bytes [STORE_DEPTH_DEF];
        int unsigned       head;
        int unsigned       tail;
        int unsigned       capacity;
        t_ring_result      due_results [$];
        int                errors;
        int                requests_seen;
        int                results_seen;

        function new();
            capacity = CAP_RESET;
            head = 0;
            tail = 0;
            errors = 0;
            requests_seen = 0;
            results_seen = 0;
        endfunction

        function int unsigned slots();
            int unsigned r;
            r = capacity + 1;
            if (r > STORE_DEPTH_DEF) begin
                r = STORE_DEPTH_DEF;
            end
            return r;
        endfunction

        function int unsigned bytes_now();
            return (tail + slots() - head) % slots();
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void set_capacity(int unsigned value);
            capacity = value;
            head = 0;
            tail = 0;
        endfunction

        function void push_result(t_status st, logic [BYTE_W-1:0] b, bit is_last);
            t_ring_result res;
            int unsigned h;
            h = bytes_now();
            res.status     = st;
            res.data_byte  = b;
            res.last       = is_last;
            res.bytes_held = h[CAP_W-1:0];
            res.full_res   = (h == slots() - 1);
            due_results.push_back(res);
        endfunction

        // Both index pointers snap back to zero whenever the ring runs empty.
        function void drop_front(int unsigned n);
            head = (head + n) % slots();
            if (head == tail) begin
                head = 0;
                tail = 0;
            end
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
                                   int unsigned cnt, bit keep);
            int unsigned r;
            int unsigned h;
            int unsigned room;
            int unsigned start;
            r = slots();
            h = bytes_now();
            room = r - 1 - h;
            start = head;
            requests_seen++;
            case (op)
                OP_APPEND, OP_PREPEND: begin
                    if ((op == OP_APPEND && cnt == 0) || cnt > WORD_BYTES_DEF) begin
                        push_result(ST_BAD_LEN, '0, 1'b1);
                    end else if (cnt > room) begin
                        push_result(ST_NO_ROOM, '0, 1'b1);
                    end else begin
                        if (op == OP_APPEND) begin
                            for (int i = 0; i < cnt; i++) begin
                                ring_bytes[tail] = data[8*i +: 8];
                                tail = (tail + 1) % r;
                            end
                        end else begin
                            head = (head + r - cnt) % r;
                            for (int i = 0; i < cnt; i++) begin
                                ring_bytes[(head + i) % r] = data[8*i +: 8];
                            end
                        end
                        push_result(ST_OK, '0, 1'b1);
                    end
                end
                OP_READ: begin
                    if (cnt > MAX_READ_DEF) begin
                        push_result(ST_BAD_LEN, '0, 1'b1);
                    end else if (cnt > h) begin
                        push_result(ST_NO_DATA, '0, 1'b1);
                    end else begin
                        // Every beat reports the fill level after the removal.
                        if (!keep) begin
                            drop_front(cnt);
                        end
                        if (cnt == 0) begin
                            push_result(ST_OK, '0, 1'b1);
                        end else begin
                            for (int k = 0; k < cnt; k++) begin
                                push_result(ST_OK, ring_bytes[(start + k) % r], k == cnt - 1);
                            end
                        end
                    end
                end
                OP_COMMIT: begin
                    if (cnt > h) begin
                        push_result(ST_NO_DATA, '0, 1'b1);
                    end else begin
                        drop_front(cnt);
                        push_result(ST_OK, '0, 1'b1);
                    end
                end
                OP_CLEAR: begin
                    head = 0;
                    tail = 0;
                    push_result(ST_OK, '0, 1'b1);
                end
                default: begin
                    push_result(ST_OK, '0, 1'b1);
                end
            endcase
        endfunction

        task report(string field, logic [CAP_W-1:0] got, logic [CAP_W-1:0] want);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("mismatch on result %0d: %s got %0h, expected %0h",
                         results_seen, field, got, want);
            end
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [BYTE_W-1:0] data_byte,
                          logic last, logic [CAP_W-1:0] bytes_held, logic full_res);
            t_ring_result want;
            results_seen++;
            if (due_results.size() == 0) begin
                report("unexpected result, status", CAP_W'(status), '0);
            end else begin
                want = due_results.pop_front();
                if (status !== want.status) begin
                    report("status", CAP_W'(status), CAP_W'(want.status));
                end
                if (data_byte !== want.data_byte) begin
                    report("data_byte", CAP_W'(data_byte), CAP_W'(want.data_byte));
                end
                if (last !== want.last) begin
                    report("last", CAP_W'(last), CAP_W'(want.last));
                end
                if (bytes_held !== want.bytes_held) begin
                    report("bytes_held", bytes_held, want.bytes_held);
                end
                if (full_res !== want.full_res) begin
                    report("full_res", CAP_W'(full_res), CAP_W'(want.full_res));
                end
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_data;
    bit               quiet = 1'b0;
    int               cycle_count = 0;
    int               phases_run = 0;

    ring_scoreboard sb = new();

    brbd_req_if req_bus ();
    brbd_rsp_if rsp_bus ();

    byte_ring_buffer_deque_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side: random back-pressure bursts, none once the run goes quiet.
    initial begin
        rsp_bus.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(rsp_bus.status, rsp_bus.data_byte, rsp_bus.last,
                            rsp_bus.bytes_held, rsp_bus.full_res);
        end
    end

    // Leaves valid high after a transaction unless a random idle gap is drawn.
    task automatic issue(logic [OP_W-1:0] op, logic [DATA_W-1:0] data, int unsigned cnt,
                         bit keep);
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.data      <= data;
        req_bus.count     <= cnt[COUNT_W-1:0];
        req_bus.keep      <= keep;
        do @(posedge i_clk); while (!req_bus.ready);
        sb.note_request(op, data, cnt % (1 << COUNT_W), keep);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(int unsigned value);
        drain();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[CAP_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_capacity(value);
    endtask

    task automatic issue_random();
        int unsigned pick;
        int unsigned h;
        int unsigned cnt;
        int unsigned lim;
        logic [OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        h = sb.bytes_now();
        if (pick < 38) begin
            op = OP_APPEND;
            cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
        end else if (pick < 55) begin
            op = OP_PREPEND;
            cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
        end else if (pick < 80) begin
            op = OP_READ;
            lim = (h < MAX_READ_DEF) ? h : MAX_READ_DEF;
            case ($urandom_range(0, 9))
                0: cnt = $urandom_range(0, 127);
                1: cnt = (h < 127) ? h + 1 : 127;
                default: cnt = $urandom_range(0, lim);
            endcase
        end else if (pick < 93) begin
            op = OP_COMMIT;
            lim = (h < 16) ? h : 16;
            cnt = ($urandom_range(0, 7) == 0) ? ((h < 127) ? h + 1 : 127)
                                              : $urandom_range(0, lim);
        end else if (pick < 96) begin
            op = OP_CLEAR;
            cnt = $urandom_range(0, 127);
        end else begin
            op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            cnt = $urandom_range(0, 127);
        end
        issue(op, {$urandom, $urandom}, cnt, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(int unsigned items);
        phases_run++;
        for (int i = 0; i < items; i++) begin
            // Halfway through, hold off until everything owed has come back.
            if (i == items / 2) begin
                drain();
            end
            issue_random();
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        req_bus.valid     <= 1'b0;
        req_bus.operation <= OP_APPEND;
        req_bus.data      <= '0;
        req_bus.count     <= '0;
        req_bus.keep      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corner cases at the reset capacity.
        issue(OP_READ, '0, 0, 1'b0);
        issue(OP_READ, '0, 1, 1'b1);
        issue(OP_COMMIT, '0, 1, 1'b0);
        issue(OP_APPEND, '1, 0, 1'b0);
        issue(OP_APPEND, '1, 9, 1'b0);
        issue(OP_PREPEND, '1, 0, 1'b0);
        issue(OP_PREPEND, '1, 9, 1'b0);
        issue(OP_APPEND, '1, 8, 1'b0);
        issue(OP_PREPEND, 64'h0123_4567_89ab_cdef, 8, 1'b0);
        issue(OP_APPEND, '0, 3, 1'b0);
        issue(OP_READ, '0, 19, 1'b1);
        issue(OP_READ, '0, MAX_READ_DEF + 1, 1'b0);
        issue(OP_READ, '0, 127, 1'b1);
        issue(OP_READ, '0, 20, 1'b0);
        issue(OP_COMMIT, '0, 2, 1'b0);
        issue(OP_READ, '0, 17, 1'b0);
        for (int i = 0; i < MAX_READ_DEF / WORD_BYTES_DEF; i++) begin
            issue(OP_APPEND, {$urandom, $urandom}, WORD_BYTES_DEF, 1'b0);
        end
        issue(OP_READ, '0, MAX_READ_DEF, 1'b0);
        issue(OP_APPEND, 64'h5a, 1, 1'b0);
        issue(OP_UNUSED_HI, '1, 127, 1'b1);
        issue(OP_CLEAR, '0, 0, 1'b0);

        run_phase(60);
        write_capacity(0);
        run_phase(15);
        write_capacity(1);
        run_phase(35);
        write_capacity(9);
        run_phase(70);
        write_capacity(2);
        run_phase(30);
        write_capacity(CAP_RESET);
        quiet = 1'b1;
        run_phase(90);

        drain();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Run covered %0d transactions in %0d phases at capacities 1023, 0, 1, 9 and 2.",
                 sb.requests_seen, phases_run);
        $display("Checked %0d result beats; %0d field mismatches.",
                 sb.results_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
